@@ rtl/assert_macros.svh @@
// Assertion macros shared by the grid-world Q-learning RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define GQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define GQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define GQ_ASSERT(lbl, clk, rst_n, prop)
`define GQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ rtl/gqls_pkg.sv @@
// Shared types, constants and helpers of the grid-world Q-learning core.
package gqls_pkg;
  localparam int MAX_CELLS = 1024;
  localparam int CELL_W    = $clog2(MAX_CELLS);
  localparam int ROW_W     = 64;
  localparam int Q_W       = 16;
  localparam int DIM_W     = 6;

  localparam logic [2:0] CFG_GRID_W   = 3'd0;
  localparam logic [2:0] CFG_GRID_H   = 3'd1;
  localparam logic [2:0] CFG_GOAL     = 3'd2;
  localparam logic [2:0] CFG_START    = 3'd3;
  localparam logic [2:0] CFG_ALPHA    = 3'd4;
  localparam logic [2:0] CFG_GAMMA    = 3'd5;
  localparam logic [2:0] CFG_REWARD   = 3'd6;

  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_UP    = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  typedef struct packed {
    logic              done;
    logic [CELL_W-1:0] quot;
    logic [DIM_W-1:0]  rem;
  } div_res_t;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(32)) r = DIM_W'(32);
    return r;
  endfunction

  function automatic logic signed [Q_W-1:0] q_lane(logic [ROW_W-1:0] row, logic [1:0] k);
    return row[Q_W*k +: Q_W];
  endfunction
endpackage

@@ rtl/gqls_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module gqls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

@@ rtl/gqls_div.sv @@
// Restoring divider, one quotient bit per cycle, splits a cell index into row and column.
module gqls_div import gqls_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [CELL_W-1:0] dividend_i,
  input  logic [DIM_W-1:0]  divisor_i,
  output div_res_t          res_o
);
  localparam int CNT_W = $clog2(CELL_W + 1);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [CELL_W-1:0] quot_q, quot_d;
  logic [DIM_W-1:0]  rem_q, rem_d;
  logic [DIM_W-1:0]  dvs_q, dvs_d;
  logic [DIM_W:0]    shifted;

  always_comb begin
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    quot_d  = quot_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    shifted = {rem_q, quot_q[CELL_W-1]};
    if (start_i) begin
      cnt_d  = CNT_W'(CELL_W);
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (cnt_q != '0) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d  = DIM_W'(shifted - {1'b0, dvs_q});
        quot_d = {quot_q[CELL_W-2:0], 1'b1};
      end else begin
        rem_d  = shifted[DIM_W-1:0];
        quot_d = {quot_q[CELL_W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign res_o = '{done: done_q, quot: quot_q, rem: rem_q};
endmodule

@@ rtl/gridworld_q_learning_step_core.sv @@
// Grid-world Q-learning step core: sequencer, shared multiplier and Q/wall memories.
// A step word passes through the row/column divider, then move, wall read, max Q, two multiplier
// passes, update and output; a load word goes straight to output. No new item is taken until
// the previous word has left the sequencer, and a held output holds the sequencer too.
// After reset a clearing pass zeroes every cell of the wall memory; no item is taken
// meanwhile, configuration writes are. Registers reset to their documented values.
`include "assert_macros.svh"
module gridworld_q_learning_step_core import gqls_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [2:0]              cfg_index_i,
  input  logic [15:0]             cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    req_type_i,
  input  logic                    explore_i,
  input  logic [1:0]              random_dir_i,
  input  logic [CELL_W-1:0]       cell_index_i,
  input  logic                    wall_flag_i,
  input  logic [ROW_W-1:0]        q_init_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [CELL_W-1:0]       new_cell_o,
  output logic [1:0]              action_o,
  output logic                    goal_reached_o,
  output logic [15:0]             episode_steps_o,
  output logic signed [Q_W-1:0]   q_updated_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_MOVE, S_WALL, S_MAXQ, S_MUL1, S_DIFF, S_MUL2, S_UPD, S_FIN
  } state_e;

  state_e state_q;

  logic [DIM_W-1:0]  grid_w_q, grid_h_q;
  logic [CELL_W-1:0] goal_q, start_q;
  logic [15:0]       alpha_q, gamma_q;
  logic [14:0]       reward_q;

  logic [CELL_W-1:0] agent_q;
  logic [1:0]        last_q;
  logic [15:0]       steps_q;
  logic [CELL_W:0]   clr_q;
  logic              clearing;

  logic              explore_q;
  logic [1:0]        rdir_q, act_q;
  logic [ROW_W-1:0]  row_q;
  logic              oog_q, stay_q, goal_hit_q, upd_q;
  logic [CELL_W-1:0] target_q, newc_q;
  logic [14:0]       best_q;
  logic signed [Q_W-1:0] qo_q;
  logic signed [17:0] d_q;
  logic signed [34:0] prod_q;

  logic [CELL_W-1:0] res_cell_q;
  logic [1:0]        res_act_q;
  logic              res_goal_q;
  logic [15:0]       res_steps_q;
  logic signed [Q_W-1:0] res_q_q;

  logic              out_valid_q;
  logic [CELL_W-1:0] out_cell_q;
  logic [1:0]        out_act_q;
  logic              out_goal_q;
  logic [15:0]       out_steps_q;
  logic signed [Q_W-1:0] out_q_q;

  logic in_acc, out_free;
  assign clearing = !clr_q[CELL_W];
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  logic [DIM_W-1:0] w_eff, h_eff;
  logic [CELL_W:0]  wh;
  assign w_eff = clamp_dim(grid_w_q);
  assign h_eff = clamp_dim(grid_h_q);
  assign wh    = {{(CELL_W+1-DIM_W){1'b0}}, w_eff} * {{(CELL_W+1-DIM_W){1'b0}}, h_eff};

  // Row and column of the agent cell.
  div_res_t div_res;
  gqls_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_acc && !req_type_i),
    .dividend_i(agent_q),
    .divisor_i (w_eff),
    .res_o     (div_res)
  );

  // Memories.
  logic              q_we, q_re, wall_we, wall_re;
  logic [CELL_W-1:0] q_waddr, q_raddr, wall_waddr, wall_raddr;
  logic [ROW_W-1:0]  q_wdata, q_rdata;
  logic              wall_wdata, wall_rdata;

  gqls_ram #(.WIDTH(ROW_W), .DEPTH(MAX_CELLS)) u_qram (
    .clk_i(clk_i), .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .re_i(q_re), .raddr_i(q_raddr), .rdata_o(q_rdata)
  );
  gqls_ram #(.WIDTH(1), .DEPTH(MAX_CELLS)) u_wram (
    .clk_i(clk_i), .we_i(wall_we), .waddr_i(wall_waddr), .wdata_i(wall_wdata),
    .re_i(wall_re), .raddr_i(wall_raddr), .rdata_o(wall_rdata)
  );

  // Greedy choice and move target, evaluated in S_MOVE on the old cell's row.
  logic [1:0]            g_act, act_sel;
  logic signed [Q_W-1:0] g_best;
  logic [DIM_W-1:0]      xx, yy, tx, ty;
  logic                  stay, oog;
  logic [CELL_W:0]       tgt;

  always_comb begin
    g_act  = last_q;
    g_best = '0;
    for (int k = 0; k < 4; k++) begin
      if (q_lane(q_rdata, 2'(k)) > g_best) begin
        g_best = q_lane(q_rdata, 2'(k));
        g_act  = 2'(k);
      end
    end
    act_sel = explore_q ? rdir_q : g_act;
    oog  = {1'b0, agent_q} >= wh;
    xx   = div_res.rem;
    yy   = div_res.quot[DIM_W-1:0];
    tx   = xx;
    ty   = yy;
    stay = 1'b0;
    case (act_sel)
      DIR_RIGHT: begin
        stay = ({1'b0, xx} + 7'd1) >= {1'b0, w_eff};
        tx   = xx + DIM_W'(1);
      end
      DIR_UP: begin
        stay = ({1'b0, yy} + 7'd1) >= {1'b0, h_eff};
        ty   = yy + DIM_W'(1);
      end
      DIR_LEFT: begin
        stay = (xx == '0);
        tx   = xx - DIM_W'(1);
      end
      default: begin
        stay = (yy == '0);
        ty   = yy - DIM_W'(1);
      end
    endcase
    tgt = {{(CELL_W+1-DIM_W){1'b0}}, ty} * {{(CELL_W+1-DIM_W){1'b0}}, w_eff}
        + {{(CELL_W+1-DIM_W){1'b0}}, tx};
  end

  // Cell after the move, once the wall bit of the target is known.
  logic [CELL_W-1:0] newc;
  always_comb begin
    if (oog_q) newc = wall_rdata ? agent_q : '0;
    else if (stay_q || wall_rdata) newc = agent_q;
    else newc = target_q;
  end

  // Largest Q above zero of the new cell.
  logic signed [Q_W-1:0] n_best;
  always_comb begin
    n_best = '0;
    for (int k = 0; k < 4; k++) begin
      if (q_lane(q_rdata, 2'(k)) > n_best) n_best = q_lane(q_rdata, 2'(k));
    end
  end

  // Shared multiplier: gamma times best, then alpha times the difference.
  logic signed [16:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [34:0] mul_p;
  assign mul_a = (state_q == S_MUL1) ? $signed({1'b0, gamma_q}) : $signed({1'b0, alpha_q});
  assign mul_b = (state_q == S_MUL1) ? $signed({3'b000, best_q}) : d_q;
  assign mul_p = 35'(mul_a) * 35'(mul_b);

  logic signed [34:0] rnd;
  logic signed [17:0] g_val, rew;
  logic signed [18:0] delta;
  logic signed [19:0] nq;
  logic signed [Q_W-1:0] nq_sat, res_val;
  logic [15:0] steps_inc;
  assign rnd   = prod_q + 35'sd32768;
  assign g_val = $signed({1'b0, rnd[32:16]});
  assign rew   = goal_hit_q ? $signed({3'b000, reward_q}) : -18'sd256;
  assign delta = rnd[34:16];
  assign nq    = 20'(qo_q) + 20'(delta);
  always_comb begin
    if (nq > 20'sd32767) nq_sat = 16'sh7fff;
    else if (nq < -20'sd32768) nq_sat = 16'sh8000;
    else nq_sat = nq[Q_W-1:0];
  end
  assign res_val   = upd_q ? nq_sat : qo_q;
  assign steps_inc = (steps_q != 16'hffff) ? steps_q + 16'd1 : steps_q;

  always_comb begin
    q_we    = 1'b0;
    q_waddr = agent_q;
    q_wdata = row_q;
    q_re    = 1'b0;
    q_raddr = agent_q;
    if (in_acc && req_type_i) begin
      q_we    = 1'b1;
      q_waddr = cell_index_i;
      q_wdata = q_init_i;
    end else if (state_q == S_UPD && upd_q) begin
      q_we = 1'b1;
      q_wdata[Q_W*act_q +: Q_W] = nq_sat;
    end
    if (in_acc && !req_type_i) q_re = 1'b1;
    if (state_q == S_WALL) begin
      q_re    = 1'b1;
      q_raddr = newc;
    end
    wall_we    = clearing || (in_acc && req_type_i);
    wall_waddr = clearing ? clr_q[CELL_W-1:0] : cell_index_i;
    wall_wdata = clearing ? 1'b0 : wall_flag_i;
    wall_re    = (state_q == S_MOVE);
    wall_raddr = oog ? '0 : tgt[CELL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      grid_w_q    <= DIM_W'(20);
      grid_h_q    <= DIM_W'(10);
      goal_q      <= '0;
      start_q     <= '0;
      alpha_q     <= 16'd6554;
      gamma_q     <= 16'd58982;
      reward_q    <= 15'd25600;
      agent_q     <= '0;
      last_q      <= '0;
      steps_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (clearing) clr_q <= clr_q + (CELL_W+1)'(1);
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_GRID_W: grid_w_q <= cfg_data_i[DIM_W-1:0];
          CFG_GRID_H: grid_h_q <= cfg_data_i[DIM_W-1:0];
          CFG_GOAL:   goal_q   <= cfg_data_i[CELL_W-1:0];
          CFG_START:  start_q  <= cfg_data_i[CELL_W-1:0];
          CFG_ALPHA:  alpha_q  <= cfg_data_i;
          CFG_GAMMA:  gamma_q  <= cfg_data_i;
          CFG_REWARD: reward_q <= cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (state_q == S_FIN && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_acc) state_q <= req_type_i ? S_FIN : S_DIV;
        end
        S_DIV:  if (div_res.done) state_q <= S_MOVE;
        S_MOVE: state_q <= S_WALL;
        S_WALL: state_q <= S_MAXQ;
        S_MAXQ: state_q <= S_MUL1;
        S_MUL1: state_q <= S_DIFF;
        S_DIFF: state_q <= S_MUL2;
        S_MUL2: state_q <= S_UPD;
        S_UPD: begin
          last_q  <= act_q;
          steps_q <= goal_hit_q ? 16'd0 : steps_inc;
          agent_q <= goal_hit_q ? start_q : newc_q;
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      explore_q   <= explore_i;
      rdir_q      <= random_dir_i;
      res_cell_q  <= agent_q;
      res_act_q   <= last_q;
      res_goal_q  <= 1'b0;
      res_steps_q <= steps_q;
      res_q_q     <= '0;
    end
    if (state_q == S_MOVE) begin
      row_q    <= q_rdata;
      act_q    <= act_sel;
      oog_q    <= oog;
      stay_q   <= stay;
      target_q <= tgt[CELL_W-1:0];
    end
    if (state_q == S_WALL) newc_q <= newc;
    if (state_q == S_MAXQ) begin
      best_q     <= n_best[14:0];
      qo_q       <= q_lane(row_q, act_q);
      goal_hit_q <= (newc_q == goal_q);
      upd_q      <= (newc_q != start_q) && (newc_q != agent_q);
    end
    if (state_q == S_MUL1 || state_q == S_MUL2) prod_q <= mul_p;
    if (state_q == S_DIFF) d_q <= rew + g_val - 18'(qo_q);
    if (state_q == S_UPD) begin
      res_cell_q  <= goal_hit_q ? start_q : newc_q;
      res_act_q   <= act_q;
      res_goal_q  <= goal_hit_q;
      res_steps_q <= steps_inc;
      res_q_q     <= res_val;
    end
    if (state_q == S_FIN && out_free) begin
      out_cell_q  <= res_cell_q;
      out_act_q   <= res_act_q;
      out_goal_q  <= res_goal_q;
      out_steps_q <= res_steps_q;
      out_q_q     <= res_q_q;
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign in_stall_o      = clearing || (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign new_cell_o      = out_cell_q;
  assign action_o        = out_act_q;
  assign goal_reached_o  = out_goal_q;
  assign episode_steps_o = out_steps_q;
  assign q_updated_o     = out_q_q;

  `GQ_ASSERT_ALWAYS(a_clear_blocks_input, clk_i, clearing |-> in_stall_o)
  `GQ_ASSERT(a_qwrite_source, clk_i, rst_ni, q_we |-> (state_q == S_UPD) || (in_acc && req_type_i))
  `GQ_ASSERT(a_fin_posts_word, clk_i, rst_ni, (state_q == S_FIN && out_free) |=> out_valid_q && state_q == S_IDLE)
endmodule
